### rtl/core/lzwe_pkg.sv
// Constants and helpers shared by the LZW byte-stream encoder.
// No dependencies.
package lzwe_pkg;

	localparam int unsigned TableEntries = 8192;
	localparam int unsigned AddrW        = $clog2(TableEntries);
	localparam int unsigned MaxCode      = 4095;
	localparam int unsigned KeyW         = 20;
	localparam int unsigned CodeW        = 12;
	localparam int unsigned EpochW       = 8;
	localparam int unsigned EntryW       = EpochW + KeyW + CodeW;

	localparam logic [CodeW-1:0] CODE_CLR   = 12'd256;
	localparam logic [CodeW-1:0] CODE_EOI   = 12'd257;
	localparam logic [12:0]      FIRST_FREE = 13'd258;
	localparam logic [3:0]       MIN_WIDTH  = 4'd9;
	localparam logic [3:0]       TOP_WIDTH  = 4'd12;
	localparam logic [12:0]      MAX_CODE_V = 13'(MaxCode);

	// pending operations of one pixel, served lowest bit first
	localparam int unsigned OP_FIRST  = 0;
	localparam int unsigned OP_PREFIX = 1;
	localparam int unsigned OP_FULL   = 2;
	localparam int unsigned OP_LASTP  = 3;
	localparam int unsigned OP_END    = 4;
	localparam int unsigned OP_FLUSH  = 5;
	localparam int unsigned NumOps    = 6;

	typedef logic [NumOps-1:0] ops_t;

	function automatic logic [AddrW-1:0] home_slot(input logic [KeyW-1:0] key);
		logic [KeyW-1:0] h;
		begin
			h = (key >> 12) ^ key;
			home_slot = h[AddrW-1:0];
		end
	endfunction

endpackage

### rtl/core/lzw_byte_stream_encoder.sv
// LZW byte-stream encoder top level: dictionary memory, probe control and bit packer.
// Depends on lzwe_pkg.
//
// Usage:
//  Input channel (pixel, last_pixel, in_valid/in_ready) takes one 8-bit pixel per
//  request; last_pixel closes the image. Output channel (out_byte, last_byte,
//  out_valid/out_ready) returns packed GIF-style LZW code bytes, LSB first,
//  last_byte set on the final byte of a compressed stream.
//  One pixel is processed at a time. The request is followed by the probes, each
//  a synchronous memory read, then a compare, and by each code written: a select,
//  a put, then the drain of the bytes it produces. Selecting the end of the pixel
//  adds a final select step. The dictionary is invalidated by an epoch tag on
//  every clear; when the 8-bit epoch wraps, a clearing pass rewrites the whole
//  memory. After reset the same clearing pass runs before in_ready rises.
//  A stalled receiver holds out_valid and the byte; the encoder waits with the
//  next byte until the output register frees, and takes no pixel meanwhile.
module lzw_byte_stream_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] pixel,
	input  logic       last_pixel,
	input  logic       in_valid,
	output logic       in_ready,
	output logic [7:0] out_byte,
	output logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SWEEP = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_CMP   = 3'd3;
	localparam logic [2:0] S_NEXT  = 3'd4;
	localparam logic [2:0] S_PUT   = 3'd5;
	localparam logic [2:0] S_DRAIN = 3'd6;

	logic [2:0] state_q;
	logic [lzwe_pkg::EntryW-1:0] mem [0:lzwe_pkg::TableEntries-1];
	logic [lzwe_pkg::EntryW-1:0] rdata_s1;
	logic mem_we;
	logic [lzwe_pkg::EntryW-1:0] mem_wdata;

	logic [lzwe_pkg::AddrW-1:0] addr_q;
	logic [lzwe_pkg::EpochW-1:0] epoch_q;
	logic [lzwe_pkg::KeyW-1:0] key_q;
	logic [7:0]  pix_q;
	logic        last_q;
	logic [11:0] prefix_q;
	logic [12:0] nfc_q;
	logic [3:0]  width_q;
	logic [19:0] buf_q;
	logic [4:0]  cnt_q;
	logic        started_q;
	lzwe_pkg::ops_t ops_q;
	logic [2:0]  cur_op_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_byte_q;

	logic [lzwe_pkg::KeyW-1:0] key_in;
	logic entry_live, entry_hit, slot_free, need_byte, flushing;
	logic [11:0] put_code;
	lzwe_pkg::ops_t last_ops, rest_ops;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_byte_q;

	assign key_in     = {prefix_q, pixel};
	assign entry_live = (rdata_s1[lzwe_pkg::EntryW-1 -: lzwe_pkg::EpochW] == epoch_q);
	assign entry_hit  = entry_live &&
		(rdata_s1[lzwe_pkg::CodeW +: lzwe_pkg::KeyW] == key_q);
	assign slot_free  = !out_valid_q || out_ready;
	assign flushing   = (cur_op_q == 3'(lzwe_pkg::OP_FLUSH));
	assign need_byte  = flushing ? (cnt_q != 5'd0) : (cnt_q >= 5'd8);

	always_comb begin
		last_ops = '0;
		if (last_q) begin
			last_ops[lzwe_pkg::OP_LASTP] = 1'b1;
			last_ops[lzwe_pkg::OP_END]   = 1'b1;
			last_ops[lzwe_pkg::OP_FLUSH] = 1'b1;
		end
		rest_ops = ops_q;
		rest_ops[lzwe_pkg::OP_FLUSH] = 1'b0;
	end

	always_comb begin
		case (cur_op_q)
			3'(lzwe_pkg::OP_FIRST): put_code = lzwe_pkg::CODE_CLR;
			3'(lzwe_pkg::OP_FULL):  put_code = lzwe_pkg::CODE_CLR;
			3'(lzwe_pkg::OP_END):   put_code = lzwe_pkg::CODE_EOI;
			default:                put_code = prefix_q;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = '0;
		if (state_q == S_SWEEP) begin
			mem_we = 1'b1;
		end else if (state_q == S_CMP && !entry_live && nfc_q < lzwe_pkg::MAX_CODE_V) begin
			mem_we    = 1'b1;
			mem_wdata = {epoch_q, key_q, nfc_q[11:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= mem_wdata;
		end
		rdata_s1 <= mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			pix_q  <= pixel;
			last_q <= last_pixel;
			key_q  <= key_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			addr_q      <= '0;
			epoch_q     <= 8'd1;
			prefix_q    <= '0;
			nfc_q       <= lzwe_pkg::FIRST_FREE;
			width_q     <= lzwe_pkg::MIN_WIDTH;
			buf_q       <= '0;
			cnt_q       <= '0;
			started_q   <= 1'b0;
			ops_q       <= '0;
			cur_op_q    <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			last_byte_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (!started_q) begin
							nfc_q     <= lzwe_pkg::FIRST_FREE;
							width_q   <= lzwe_pkg::MIN_WIDTH;
							buf_q     <= '0;
							cnt_q     <= '0;
							prefix_q  <= {4'd0, pixel};
							started_q <= 1'b1;
							ops_q     <= {last_pixel, last_pixel, last_pixel, 3'b001};
							if (epoch_q == '1) begin
								epoch_q <= 8'd1;
								addr_q  <= '0;
								state_q <= S_SWEEP;
							end else begin
								epoch_q <= epoch_q + 8'd1;
								state_q <= S_NEXT;
							end
						end else begin
							addr_q  <= lzwe_pkg::home_slot(key_in);
							state_q <= S_RD;
						end
					end
				end
				S_SWEEP: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == '1) begin
						state_q <= S_NEXT;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (entry_hit) begin
						prefix_q <= rdata_s1[11:0];
						ops_q    <= last_ops;
						state_q  <= S_NEXT;
					end else if (entry_live) begin
						addr_q  <= addr_q + 1'b1;
						state_q <= S_RD;
					end else begin
						ops_q <= last_ops;
						ops_q[lzwe_pkg::OP_PREFIX] <= 1'b1;
						ops_q[lzwe_pkg::OP_FULL]   <= (nfc_q >= lzwe_pkg::MAX_CODE_V);
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					state_q <= S_PUT;
					if (ops_q[lzwe_pkg::OP_FIRST]) begin
						cur_op_q <= 3'(lzwe_pkg::OP_FIRST);
						ops_q[lzwe_pkg::OP_FIRST] <= 1'b0;
					end else if (ops_q[lzwe_pkg::OP_PREFIX]) begin
						cur_op_q <= 3'(lzwe_pkg::OP_PREFIX);
						ops_q[lzwe_pkg::OP_PREFIX] <= 1'b0;
					end else if (ops_q[lzwe_pkg::OP_FULL]) begin
						cur_op_q <= 3'(lzwe_pkg::OP_FULL);
						ops_q[lzwe_pkg::OP_FULL] <= 1'b0;
					end else if (ops_q[lzwe_pkg::OP_LASTP]) begin
						cur_op_q <= 3'(lzwe_pkg::OP_LASTP);
						ops_q[lzwe_pkg::OP_LASTP] <= 1'b0;
					end else if (ops_q[lzwe_pkg::OP_END]) begin
						cur_op_q <= 3'(lzwe_pkg::OP_END);
						ops_q[lzwe_pkg::OP_END] <= 1'b0;
					end else if (ops_q[lzwe_pkg::OP_FLUSH]) begin
						cur_op_q <= 3'(lzwe_pkg::OP_FLUSH);
						ops_q[lzwe_pkg::OP_FLUSH] <= 1'b0;
						state_q  <= S_DRAIN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_PUT: begin
					buf_q <= buf_q | (20'(put_code) << cnt_q);
					cnt_q <= cnt_q + 5'(width_q);
					if (nfc_q >= (13'd1 << width_q) && width_q < lzwe_pkg::TOP_WIDTH) begin
						width_q <= width_q + 4'd1;
					end
					state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (need_byte) begin
						if (slot_free) begin
							out_valid_q <= 1'b1;
							out_byte_q  <= buf_q[7:0];
							last_byte_q <= last_q && (rest_ops == '0) && (cnt_q <= 5'd8);
							buf_q       <= buf_q >> 8;
							cnt_q       <= (cnt_q >= 5'd8) ? cnt_q - 5'd8 : 5'd0;
						end
					end else begin
						state_q <= S_NEXT;
						case (cur_op_q)
							3'(lzwe_pkg::OP_PREFIX): begin
								prefix_q <= {4'd0, pix_q};
								if (!ops_q[lzwe_pkg::OP_FULL]) begin
									nfc_q <= nfc_q + 13'd1;
								end
							end
							3'(lzwe_pkg::OP_FULL): begin
								nfc_q   <= lzwe_pkg::FIRST_FREE;
								width_q <= lzwe_pkg::MIN_WIDTH;
								if (epoch_q == '1) begin
									epoch_q <= 8'd1;
									addr_q  <= '0;
									state_q <= S_SWEEP;
								end else begin
									epoch_q <= epoch_q + 8'd1;
								end
							end
							3'(lzwe_pkg::OP_FLUSH): begin
								started_q <= 1'b0;
								buf_q     <= '0;
								cnt_q     <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 5'd19)
		else $error("bit count overflow");
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		width_q >= lzwe_pkg::MIN_WIDTH && width_q <= lzwe_pkg::TOP_WIDTH)
		else $error("code width out of range");
	a_nfc_range: assert property (@(posedge clk) disable iff (!arst_n)
		nfc_q <= lzwe_pkg::MAX_CODE_V)
		else $error("next free code past limit");
	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> $past(state_q) == S_RD)
		else $error("compare without read");
`endif

endmodule
